### rtl/core/spr_pkg.sv
`default_nettype none

package spr_pkg;

    localparam int C_BYTE_W            = 8;
    localparam int C_LEN_W             = 4;
    localparam int C_CMD_BYTES         = 8;
    localparam int C_WORD_W            = 64;
    localparam int C_APB_DATA_W        = 64;
    localparam int C_APB_ADDR_W        = 5;
    localparam int C_QUEUE_DEPTH       = 2;
    localparam int C_MAX_PATTERN_BYTES = 8;
    localparam int C_MAX_REPLACE_BYTES = 8;

    localparam logic [C_WORD_W-1:0] C_RST_PATTERN_BYTES  = '0;
    localparam logic [C_LEN_W-1:0]  C_RST_PATTERN_LENGTH = 4'd1;
    localparam logic [C_WORD_W-1:0] C_RST_REPLACE_BYTES  = '0;
    localparam logic [C_LEN_W-1:0]  C_RST_REPLACE_LENGTH = 4'd0;

    // register index = paddr[4:3]
    typedef enum logic [1:0] {
        REG_PATTERN_BYTES,
        REG_PATTERN_LENGTH,
        REG_REPLACE_BYTES,
        REG_REPLACE_LENGTH
    } t_reg_idx;

    typedef struct packed {
        logic [C_WORD_W-1:0] pattern_bytes;
        logic [C_LEN_W-1:0]  pattern_length;
        logic [C_WORD_W-1:0] replacement_bytes;
        logic [C_LEN_W-1:0]  replacement_length;
    } t_cfg;

    // one queued command: emit num bytes of data, oldest in slot 0;
    // num == 0 only with last set -> empty end marker
    typedef struct packed {
        logic [C_CMD_BYTES-1:0][C_BYTE_W-1:0] data;
        logic [C_LEN_W-1:0]                   num;
        logic                                 last;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/core/spr_stream_if.sv
`default_nettype none

interface spr_in_if;
    logic                          valid;
    logic                          ready;
    logic [spr_pkg::C_BYTE_W-1:0]  text_byte;
    logic                          end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface spr_out_if;
    logic                          valid;
    logic                          ready;
    logic [spr_pkg::C_BYTE_W-1:0]  out_byte;
    logic                          is_empty;
    logic                          out_last;

    modport source (output valid, output out_byte, output is_empty, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input is_empty, input out_last,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/stream_pattern_replace_unit.sv
// Path: an accepted word is written into the command queue, then expanded through the registered output stage.
// Throughput: one input word per cycle while each word yields at most one result and the output is ready;
//   a word that yields k results (match replacement or end-of-text flush, k <= 8)
//   holds the output stage until all k are taken; the 2-entry command queue then stalls input.
// Reset: i_rst_n synchronous, active low; empties the window, queue and output
//   stage and loads the config registers with their reset values.
`default_nettype none

module stream_pattern_replace_unit #(
    parameter int P_MAX_PATTERN_BYTES = spr_pkg::C_MAX_PATTERN_BYTES,
    parameter int P_MAX_REPLACE_BYTES = spr_pkg::C_MAX_REPLACE_BYTES
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    spr_in_if.sink                                i_in,
    spr_out_if.source                             o_out,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [spr_pkg::C_APB_ADDR_W-1:0] paddr,
    input  wire logic [spr_pkg::C_APB_DATA_W-1:0] pwdata,
    output logic      [spr_pkg::C_APB_DATA_W-1:0] prdata,
    output logic                                  pready
);
    import spr_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;
    t_cmd w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    // APB register file: pattern/replacement bytes and lengths
    spr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Front: appends each byte to the pending window, tests for a match and
    // turns the step into at most one command (bytes to emit + count + last flag).
    spr_front #(
        .P_MAX_PATTERN_BYTES (P_MAX_PATTERN_BYTES),
        .P_MAX_REPLACE_BYTES (P_MAX_REPLACE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (w_cfg),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_cmd)
    );

    // Short command queue decoupling the front from output backpressure
    spr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // Back: expands the head command into result words, one per cycle while the
    // output is ready, through a registered output stage
    spr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("command queue overflow");

    // an empty marker is always the final word of its text and carries a zero byte
    a_empty_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.is_empty) |-> (o_out.out_last && (o_out.out_byte == '0)))
        else $error("malformed end marker");

    // an accepted end-of-text word always leaves a command queued
    a_last_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.end_of_text) |=> !w_empty)
        else $error("end of text lost");

endmodule

`default_nettype wire

### rtl/core/spr_cfg.sv
`default_nettype none

module spr_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [spr_pkg::C_APB_ADDR_W-1:0] paddr,
    input  wire logic [spr_pkg::C_APB_DATA_W-1:0] pwdata,
    output logic      [spr_pkg::C_APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    output spr_pkg::t_cfg                        o_cfg
);
    import spr_pkg::*;

    logic [C_WORD_W-1:0] r_pattern_bytes;
    logic [C_LEN_W-1:0]  r_pattern_length;
    logic [C_WORD_W-1:0] r_replace_bytes;
    logic [C_LEN_W-1:0]  r_replace_length;
    logic                w_wr;
    t_reg_idx            w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= C_RST_PATTERN_BYTES;
            r_pattern_length <= C_RST_PATTERN_LENGTH;
            r_replace_bytes  <= C_RST_REPLACE_BYTES;
            r_replace_length <= C_RST_REPLACE_LENGTH;
        end else if (w_wr) begin
            case (w_idx)
                REG_PATTERN_BYTES:  r_pattern_bytes  <= pwdata[C_WORD_W-1:0];
                REG_PATTERN_LENGTH: r_pattern_length <= pwdata[C_LEN_W-1:0];
                REG_REPLACE_BYTES:  r_replace_bytes  <= pwdata[C_WORD_W-1:0];
                REG_REPLACE_LENGTH: r_replace_length <= pwdata[C_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PATTERN_BYTES:  prdata = C_APB_DATA_W'(r_pattern_bytes);
            REG_PATTERN_LENGTH: prdata = C_APB_DATA_W'(r_pattern_length);
            REG_REPLACE_BYTES:  prdata = C_APB_DATA_W'(r_replace_bytes);
            REG_REPLACE_LENGTH: prdata = C_APB_DATA_W'(r_replace_length);
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.pattern_bytes      = r_pattern_bytes;
    assign o_cfg.pattern_length     = r_pattern_length;
    assign o_cfg.replacement_bytes  = r_replace_bytes;
    assign o_cfg.replacement_length = r_replace_length;

endmodule

`default_nettype wire

### rtl/core/spr_front.sv
`default_nettype none

module spr_front #(
    parameter int P_MAX_PATTERN_BYTES = spr_pkg::C_MAX_PATTERN_BYTES,
    parameter int P_MAX_REPLACE_BYTES = spr_pkg::C_MAX_REPLACE_BYTES
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    spr_in_if.sink             i_in,
    input  spr_pkg::t_cfg      i_cfg,
    input  wire logic          i_full,
    output logic               o_push,
    output spr_pkg::t_cmd      o_cmd
);
    import spr_pkg::*;

    // window depth and caps clipped to the 8-byte config registers
    localparam int W    = (P_MAX_PATTERN_BYTES < C_CMD_BYTES) ? P_MAX_PATTERN_BYTES
                                                              : C_CMD_BYTES;
    localparam int RCAP = (P_MAX_REPLACE_BYTES < C_CMD_BYTES) ? P_MAX_REPLACE_BYTES
                                                              : C_CMD_BYTES;
    localparam int CW   = $clog2(W + 1);

    logic [W-1:0][C_BYTE_W-1:0] r_win,   n_win;
    logic [CW-1:0]              r_count, n_count;

    logic [W-1:0][C_BYTE_W-1:0] w_win_app;
    logic [CW-1:0]              w_count_app;
    logic [C_LEN_W-1:0]         w_plen;
    logic [C_LEN_W-1:0]         w_rlen;
    logic                       w_full_win;
    logic                       w_match;
    logic                       w_pop;
    logic                       w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_plen = C_LEN_W'(1);
        end else if (i_cfg.pattern_length > C_LEN_W'(W)) begin
            w_plen = C_LEN_W'(W);
        end else begin
            w_plen = i_cfg.pattern_length;
        end
        if (i_cfg.replacement_length > C_LEN_W'(RCAP)) begin
            w_rlen = C_LEN_W'(RCAP);
        end else begin
            w_rlen = i_cfg.replacement_length;
        end
    end

    // window with the new byte appended at the fill position
    assign w_count_app = r_count + CW'(1);
    always_comb begin
        for (int i = 0; i < W; i++) begin
            w_win_app[i] = (CW'(i) == r_count) ? i_in.text_byte : r_win[i];
        end
    end

    assign w_full_win = (C_LEN_W'(w_count_app) == w_plen);
    assign w_pop      = (C_LEN_W'(w_count_app) >= w_plen);

    always_comb begin
        w_match = w_full_win;
        for (int i = 0; i < W; i++) begin
            if ((C_LEN_W'(i) < w_plen) &&
                (w_win_app[i] != i_cfg.pattern_bytes[C_BYTE_W*i +: C_BYTE_W])) begin
                w_match = 1'b0;
            end
        end
    end

    always_comb begin
        o_cmd.last = i_in.end_of_text;
        for (int j = 0; j < C_CMD_BYTES; j++) begin
            if (w_match) begin
                o_cmd.data[j] = i_cfg.replacement_bytes[C_BYTE_W*j +: C_BYTE_W];
            end else if (j < W) begin
                o_cmd.data[j] = w_win_app[j];
            end else begin
                o_cmd.data[j] = '0;
            end
        end
        if (w_match) begin
            o_cmd.num = w_rlen;
        end else if (i_in.end_of_text) begin
            o_cmd.num = C_LEN_W'(w_count_app);   // flush whole window
        end else if (w_pop) begin
            o_cmd.num = C_LEN_W'(1);
        end else begin
            o_cmd.num = '0;
        end
        o_push = w_accept && (i_in.end_of_text || (o_cmd.num != '0));
    end

    always_comb begin
        n_win   = r_win;
        n_count = r_count;
        if (w_accept) begin
            if (w_match || i_in.end_of_text) begin
                n_count = '0;
            end else if (w_pop) begin
                n_count = w_count_app - CW'(1);
                for (int i = 0; i < W - 1; i++) begin
                    n_win[i] = w_win_app[i+1];
                end
                n_win[W-1] = w_win_app[W-1];
            end else begin
                n_count = w_count_app;
                n_win   = w_win_app;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

`default_nettype wire

### rtl/core/spr_queue.sv
`default_nettype none

module spr_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  spr_pkg::t_cmd  i_cmd,
    input  wire logic      i_pop,
    output spr_pkg::t_cmd  o_head,
    output logic           o_full,
    output logic           o_empty
);
    import spr_pkg::*;

    localparam int PW = (C_QUEUE_DEPTH > 1) ? $clog2(C_QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(C_QUEUE_DEPTH + 1);

    t_cmd          r_mem [C_QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [NW-1:0] r_num,    n_num;

    assign o_full  = (r_num == NW'(C_QUEUE_DEPTH));
    assign o_empty = (r_num == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_num    = r_num;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(C_QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(C_QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_num = r_num + NW'(1);
        end else if (i_pop && !i_push) begin
            n_num = r_num - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_num    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_num    <= n_num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

### rtl/core/spr_back.sv
`default_nettype none

module spr_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  spr_pkg::t_cmd  i_head,
    input  wire logic      i_empty,
    output logic           o_pop,
    spr_out_if.source      o_out
);
    import spr_pkg::*;

    localparam int IW = $clog2(C_CMD_BYTES);

    logic [IW-1:0]       r_idx,   n_idx;
    logic                r_valid, n_valid;
    logic [C_BYTE_W-1:0] r_byte,  n_byte;
    logic                r_empty, n_empty;
    logic                r_last,  n_last;
    logic                w_load;
    logic                w_final;

    assign w_load  = !i_empty && (!r_valid || o_out.ready);
    assign w_final = (i_head.num == '0) || (C_LEN_W'(r_idx) == i_head.num - C_LEN_W'(1));
    assign o_pop   = w_load && w_final;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && !o_out.ready;
        n_byte  = r_byte;
        n_empty = r_empty;
        n_last  = r_last;
        if (w_load) begin
            n_valid = 1'b1;
            if (i_head.num == '0) begin
                n_byte  = '0;           // end marker, no byte
                n_empty = 1'b1;
                n_last  = 1'b1;
            end else begin
                n_byte  = i_head.data[r_idx];
                n_empty = 1'b0;
                n_last  = i_head.last && w_final;
            end
            n_idx = w_final ? '0 : r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte  <= n_byte;
        r_empty <= n_empty;
        r_last  <= n_last;
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.is_empty = r_empty;
    assign o_out.out_last = r_last;

endmodule

`default_nettype wire
